FILE: src/rar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;
  localparam int WIDTH = 32;
  localparam int MW = 2 * WIDTH + 1;
  localparam int CW = $clog2(MW + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_SUM, ST_GCD, ST_DIVN, ST_DIVD, ST_OUT
  } state_t;

  typedef logic [MW-1:0] mag_t;
endpackage
`default_nettype wire

FILE: src/rar_divu.sv
`timescale 1ns / 1ps
`default_nettype none
module rar_divu (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire rar_pkg::mag_t   dividend,
  input  wire rar_pkg::mag_t   divisor,
  output logic                 busy,
  output rar_pkg::mag_t        quot,
  output rar_pkg::mag_t        rem
);
  rar_pkg::mag_t q_r, q_nxt, r_r, r_nxt, d_r;
  logic [rar_pkg::CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [rar_pkg::MW:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {r_r, q_r[rar_pkg::MW-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend;
      r_nxt = '0;
      cnt_nxt = rar_pkg::CW'(rar_pkg::MW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[rar_pkg::MW]) begin
        r_nxt = trial[rar_pkg::MW-1:0];
        q_nxt = {q_r[rar_pkg::MW-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[rar_pkg::MW-2:0], q_r[rar_pkg::MW-1]};
        q_nxt = {q_r[rar_pkg::MW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rar_pkg::CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) d_r <= divisor;
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem = r_r;

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0) else $error("counter live while idle");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("start did not raise busy");
  a_remlt: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) && d_r != '0 |-> r_r < d_r) else $error("remainder too large");
endmodule
`default_nettype wire

FILE: src/rational_arith_reduce_top.sv
// Sequence: operand products in states M1 to M3 (and M4 for multiply), the sum in
// SUM, then Euclid remainder steps in GCD; a zero numerator goes straight to OUT.
// One shared restoring divider (one quotient bit per cycle over 65 bits)
// does each remainder and the two final divisions.
// Flow: one item at a time; in_ready is high only while idle, so no new item
// enters before the last one is done; a waiting result holds the sequencer in OUT.
// Reset: synchronous active-low rst_n returns the sequencer to idle, no result.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_reduce_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic signed [31:0] in_a_num,
  input  wire logic signed [31:0] in_a_denom,
  input  wire logic signed [31:0] in_b_num,
  input  wire logic signed [31:0] in_b_denom,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_res_num,
  output logic signed [31:0] out_res_denom,
  output logic             out_overflow,
  output logic             out_less,
  output logic             out_equal,
  output logic             out_greater
);
  localparam int W = rar_pkg::WIDTH;
  localparam int MW = rar_pkg::MW;

  rar_pkg::state_t st_r, st_nxt;
  logic [1:0] op_r;
  logic signed [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic [W-1:0] ma, mb;
  logic sa, sb;
  logic [2*W-1:0] prod;
  logic [1:0] msel;
  rar_pkg::mag_t p1_r, p2_r, mn_r, md_r, ga_r, gb_r;
  logic [W-1:0] gq_r;
  logic n1_r, n2_r, nn_r, nd_r, pneg;
  logic [MW:0] dif;
  logic dv_start, dv_busy, started_r;
  rar_pkg::mag_t dv_a, dv_b, dv_q, dv_rem;
  logic ov_r, out_valid_r;
  logic signed [31:0] rn_r, rd_r;
  logic lt_r, eq_r, gt_r;
  logic signed [31:0] res_num_r, res_denom_r;
  logic res_ovf_r, res_lt_r, res_eq_r, res_gt_r;
  logic ovn, ovd;
  rar_pkg::mag_t lim;

  always_comb begin
    case (msel)
      2'd0: begin ma = an_r; sa = an_r[W-1]; mb = bd_r; sb = bd_r[W-1]; end
      2'd1: begin ma = ad_r; sa = ad_r[W-1]; mb = bn_r; sb = bn_r[W-1]; end
      2'd2: begin ma = an_r; sa = an_r[W-1]; mb = bn_r; sb = bn_r[W-1]; end
      default: begin ma = ad_r; sa = ad_r[W-1]; mb = bd_r; sb = bd_r[W-1]; end
    endcase
    if (sa) ma = -ma;
    if (sb) mb = -mb;
    prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
    pneg = (prod != '0) && (sa != sb);
  end

  always_comb begin
    case (st_r)
      rar_pkg::ST_M1: msel = 2'd0;
      rar_pkg::ST_M2: msel = 2'd1;
      rar_pkg::ST_M4: msel = 2'd2;
      default: msel = 2'd3;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rar_pkg::ST_IDLE: if (in_valid) st_nxt = rar_pkg::ST_M1;
      rar_pkg::ST_M1: st_nxt = rar_pkg::ST_M2;
      rar_pkg::ST_M2: st_nxt = rar_pkg::ST_M3;
      rar_pkg::ST_M3:
        st_nxt = (op_r == rar_pkg::OP_MUL) ? rar_pkg::ST_M4 : rar_pkg::ST_SUM;
      rar_pkg::ST_M4: st_nxt = rar_pkg::ST_SUM;
      rar_pkg::ST_SUM: st_nxt = rar_pkg::ST_GCD;
      rar_pkg::ST_GCD:
        if (mn_r == '0) st_nxt = rar_pkg::ST_OUT;
        else if (gb_r == '0) st_nxt = rar_pkg::ST_DIVN;
      rar_pkg::ST_DIVN: if (started_r && !dv_busy) st_nxt = rar_pkg::ST_DIVD;
      rar_pkg::ST_DIVD: if (started_r && !dv_busy) st_nxt = rar_pkg::ST_OUT;
      rar_pkg::ST_OUT: if (!out_valid_r || out_ready) st_nxt = rar_pkg::ST_IDLE;
      default: st_nxt = rar_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    dv_start = 1'b0;
    dv_a = ga_r;
    dv_b = gb_r;
    case (st_r)
      rar_pkg::ST_GCD: dv_start = !started_r && gb_r != '0 && mn_r != '0;
      rar_pkg::ST_DIVN: begin dv_a = mn_r; dv_b = ga_r; dv_start = !started_r; end
      rar_pkg::ST_DIVD: begin dv_a = md_r; dv_b = ga_r; dv_start = !started_r; end
      default: dv_start = 1'b0;
    endcase
  end

  rar_divu u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .busy(dv_busy), .quot(dv_q), .rem(dv_rem)
  );

  assign dif = {1'b0, p1_r} - {1'b0, p2_r};
  assign lim = MW'(1) << (W - 1);
  assign ovn = nn_r ? (dv_q > lim) : (dv_q >= lim);
  assign ovd = nd_r ? (dv_q > lim) : (dv_q >= lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rar_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      started_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == rar_pkg::ST_OUT && st_nxt == rar_pkg::ST_IDLE) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (st_nxt != st_r) started_r <= 1'b0;
      else if (dv_start) started_r <= 1'b1;
      else if (st_r == rar_pkg::ST_GCD && started_r && !dv_busy) started_r <= 1'b0;
    end
    case (st_r)
      rar_pkg::ST_IDLE: begin
        op_r <= in_opcode;
        an_r <= in_a_num[W-1:0];
        ad_r <= in_a_denom[W-1:0];
        bn_r <= in_b_num[W-1:0];
        bd_r <= in_b_denom[W-1:0];
      end
      rar_pkg::ST_M1: begin p1_r <= MW'(prod); n1_r <= pneg; end
      rar_pkg::ST_M2: begin
        p2_r <= MW'(prod);
        n2_r <= (op_r == rar_pkg::OP_SUB && prod != '0) ? !pneg : pneg;
        lt_r <= (n1_r != pneg) ? n1_r :
                (n1_r ? (p1_r > MW'(prod)) : (p1_r < MW'(prod)));
        eq_r <= (n1_r == pneg) && (p1_r == MW'(prod));
        gt_r <= (n1_r != pneg) ? pneg :
                (n1_r ? (p1_r < MW'(prod)) : (p1_r > MW'(prod)));
      end
      rar_pkg::ST_M3: begin md_r <= MW'(prod); nd_r <= pneg; end
      rar_pkg::ST_M4: begin p1_r <= MW'(prod); n1_r <= pneg; end
      rar_pkg::ST_SUM: begin
        if (op_r == rar_pkg::OP_MUL || op_r == rar_pkg::OP_DIV) begin
          mn_r <= p1_r; nn_r <= n1_r; ga_r <= p1_r;
        end else if (n1_r == n2_r) begin
          mn_r <= p1_r + p2_r; nn_r <= n1_r; ga_r <= p1_r + p2_r;
        end else if (!dif[MW]) begin
          mn_r <= dif[MW-1:0]; nn_r <= n1_r && dif != '0; ga_r <= dif[MW-1:0];
        end else begin
          mn_r <= p2_r - p1_r; nn_r <= n2_r; ga_r <= p2_r - p1_r;
        end
        if (op_r == rar_pkg::OP_DIV) begin md_r <= p2_r; nd_r <= n2_r; end
        gb_r <= (op_r == rar_pkg::OP_DIV) ? p2_r : md_r;
      end
      rar_pkg::ST_GCD:
        if (started_r && !dv_busy) begin ga_r <= gb_r; gb_r <= dv_rem; end
      rar_pkg::ST_DIVN:
        if (started_r && !dv_busy) begin
          gq_r <= dv_q[W-1:0];
          ov_r <= ovn;
        end
      rar_pkg::ST_DIVD:
        if (started_r && !dv_busy) begin
          rn_r <= 32'(signed'(nn_r ? W'(-gq_r) : gq_r));
          rd_r <= 32'(signed'(nd_r ? W'(-dv_q[W-1:0]) : dv_q[W-1:0]));
          ov_r <= ov_r | ovd;
        end
      rar_pkg::ST_OUT:
        if (st_nxt == rar_pkg::ST_IDLE) begin
          res_num_r <= (mn_r == '0) ? 32'sd0 : rn_r;
          res_denom_r <= (mn_r == '0) ? 32'sd1 : rd_r;
          res_ovf_r <= (mn_r != '0) && ov_r;
          res_lt_r <= lt_r;
          res_eq_r <= eq_r;
          res_gt_r <= gt_r;
        end
      default: ;
    endcase
  end

  assign in_ready = (st_r == rar_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res_num = res_num_r;
  assign out_res_denom = res_denom_r;
  assign out_overflow = res_ovf_r;
  assign out_less = res_lt_r;
  assign out_equal = res_eq_r;
  assign out_greater = res_gt_r;

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({res_lt_r, res_eq_r, res_gt_r})) else $error("flags not onehot");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != rar_pkg::ST_IDLE |-> !in_ready) else $error("ready while busy");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == rar_pkg::ST_OUT |=> out_valid_r) else $error("result dropped");
endmodule
`default_nettype wire
